@@ src/psrl_pkg.sv @@
// Package for the per-source connection rate limiter.
// Holds interval, state, status, op and register codes of the unit. No dependencies.
`default_nettype none
package psrl_pkg;
   localparam int unsigned IntervalWidth = 20;
   localparam logic [IntervalWidth-1:0] IntervalReset = 20'd1000;

   typedef enum logic [2:0] {
      ST_KNOWN_OK   = 3'd0,
      ST_TOO_SOON   = 3'd1,
      ST_NEW_STORED = 3'd2,
      ST_NEW_FULL   = 3'd3,
      ST_OVERFLOW   = 3'd4,
      ST_CLEARED    = 3'd5
   } status_type;

   typedef enum logic [0:0] {
      OP_CONNECT = 1'b0,
      OP_CLEAR   = 1'b1
   } op_type;

   typedef enum logic [0:0] {
      REG_MIN_INTERVAL = 1'b0
   } reg_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SEARCH,
      S_PROBE,
      S_DECIDE,
      S_SHIFT_RD,
      S_SHIFT_WR,
      S_DONE
   } state_type;
endpackage
`default_nettype wire

@@ src/psrl_table_mem.sv @@
// Entry memory of the rate limiter: address key and last accepted tick per entry.
// Single write port, single registered read port. Uses no package.
`default_nettype none
module psrl_table_mem #(
   parameter int unsigned DEPTH = 256,
   parameter int unsigned AW    = 8
) (
   input  wire logic          clock,
   input  wire logic          rd_en,
   input  wire logic [AW-1:0] rd_addr,
   output logic [63:0]        rd_data,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [63:0]   wr_data
);
   logic [63:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end
endmodule
`default_nettype wire

@@ src/per_source_connection_rate_limiter_unit.sv @@
// Per-source connection rate limiter: sequencer, registers and memory instance.
// Depends on psrl_pkg and psrl_table_mem.
//
// One request at a time; busy is high while it is worked on. A clear goes straight to
// the finish state. In a lookup each binary search step is one memory read and one
// compare; then the final entry is fetched, the decision is made and the request ends.
// Inserting a new address reads and then writes every entry above its position and
// ends with the final write of the new entry, since the shift goes through the
// memory's single read port and single write port one entry at a time.
// The result is shown on rsp_valid for one cycle and cannot be stalled.
// No clearing pass: the entry count bounds every read.
`default_nettype none
module per_source_connection_rate_limiter_unit #(
   parameter int unsigned TABLE_DEPTH = 256
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic        req_operation,
   input  wire logic signed [31:0] req_source_address,
   input  wire logic signed [31:0] req_now_ticks,
   output logic             rsp_valid,
   output logic             rsp_accepted,
   output logic [2:0]       rsp_status,
   output logic             rsp_table_full,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [1:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);
   localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
   localparam logic [CW-1:0] DepthC = CW'(TABLE_DEPTH);
   localparam logic [1:0] MinIntervalAddr = 2'(4 * psrl_pkg::REG_MIN_INTERVAL);

   psrl_pkg::state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] lo_ff, lo_in, hi_ff, hi_in, ptr_ff, ptr_in;
   logic [psrl_pkg::IntervalWidth-1:0] interval_ff;
   logic signed [31:0] addr_ff, now_ff;
   logic op_ff;
   logic acc_ff, acc_in, full_ff, full_in, valid_ff, valid_in;
   logic [2:0] stat_ff, stat_in;

   logic rd_en, wr_en;
   logic [AW-1:0] rd_addr, wr_addr;
   logic [63:0] rd_data, wr_data;
   logic [CW-1:0] mid;
   logic signed [32:0] due;

   psrl_table_mem #(.DEPTH(TABLE_DEPTH), .AW(AW)) u_mem (
      .clock(clock), .rd_en(rd_en), .rd_addr(rd_addr), .rd_data(rd_data),
      .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data)
   );

   assign pready = 1'b1;
   assign prdata = (paddr == MinIntervalAddr) ? {12'd0, interval_ff} : 32'd0;
   assign busy = (state_ff != psrl_pkg::S_IDLE);
   assign rsp_valid = valid_ff;
   assign rsp_accepted = acc_ff;
   assign rsp_status = stat_ff;
   assign rsp_table_full = full_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ff <= psrl_pkg::IntervalReset;
      end else if (psel && penable && pwrite && paddr == MinIntervalAddr) begin
         interval_ff <= pwdata[psrl_pkg::IntervalWidth-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= psrl_pkg::S_IDLE;
         count_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         valid_ff <= valid_in;
      end
      lo_ff <= lo_in;
      hi_ff <= hi_in;
      ptr_ff <= ptr_in;
      acc_ff <= acc_in;
      stat_ff <= stat_in;
      full_ff <= full_in;
      if (start && !busy) begin
         op_ff <= req_operation;
         addr_ff <= req_source_address;
         now_ff <= req_now_ticks;
      end
   end

   assign mid = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign due = 33'(signed'(rd_data[31:0])) + 33'(signed'({1'b0, interval_ff}));

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      lo_in = lo_ff;
      hi_in = hi_ff;
      ptr_in = ptr_ff;
      acc_in = acc_ff;
      stat_in = stat_ff;
      full_in = full_ff;
      valid_in = 1'b0;
      rd_en = 1'b0;
      rd_addr = mid[AW-1:0];
      wr_en = 1'b0;
      wr_addr = ptr_ff[AW-1:0];
      wr_data = {addr_ff, now_ff};
      case (state_ff)
         psrl_pkg::S_IDLE: begin
            if (start) begin
               lo_in = '0;
               hi_in = count_ff;
               state_in = psrl_pkg::S_SEARCH;
            end
         end
         psrl_pkg::S_SEARCH: begin
            if (op_ff == psrl_pkg::OP_CLEAR) begin
               count_in = '0;
               acc_in = 1'b0;
               stat_in = psrl_pkg::ST_CLEARED;
               state_in = psrl_pkg::S_DONE;
            end else if (lo_ff < hi_ff) begin
               rd_en = 1'b1;
               state_in = psrl_pkg::S_PROBE;
            end else begin
               rd_en = (lo_ff < count_ff);
               rd_addr = lo_ff[AW-1:0];
               state_in = psrl_pkg::S_DECIDE;
            end
         end
         psrl_pkg::S_PROBE: begin
            if (signed'(rd_data[63:32]) < addr_ff) begin
               lo_in = mid + 1'b1;
            end else begin
               hi_in = mid;
            end
            state_in = psrl_pkg::S_SEARCH;
         end
         psrl_pkg::S_DECIDE: begin
            state_in = psrl_pkg::S_DONE;
            if (lo_ff < count_ff && signed'(rd_data[63:32]) == addr_ff) begin
               if (due > 33'sd2147483647) begin
                  acc_in = 1'b0;
                  stat_in = psrl_pkg::ST_OVERFLOW;
               end else if (due <= 33'(now_ff)) begin
                  wr_en = 1'b1;
                  wr_addr = lo_ff[AW-1:0];
                  acc_in = 1'b1;
                  stat_in = psrl_pkg::ST_KNOWN_OK;
               end else begin
                  acc_in = 1'b0;
                  stat_in = psrl_pkg::ST_TOO_SOON;
               end
            end else if (count_ff >= DepthC) begin
               acc_in = 1'b1;
               stat_in = psrl_pkg::ST_NEW_FULL;
            end else begin
               acc_in = 1'b1;
               stat_in = psrl_pkg::ST_NEW_STORED;
               ptr_in = count_ff;
               state_in = psrl_pkg::S_SHIFT_RD;
            end
         end
         psrl_pkg::S_SHIFT_RD: begin
            // Move entries up from the top down to the insert point.
            if (ptr_ff == lo_ff) begin
               wr_en = 1'b1;
               count_in = count_ff + 1'b1;
               state_in = psrl_pkg::S_DONE;
            end else begin
               rd_en = 1'b1;
               rd_addr = AW'(ptr_ff - 1'b1);
               state_in = psrl_pkg::S_SHIFT_WR;
            end
         end
         psrl_pkg::S_SHIFT_WR: begin
            wr_en = 1'b1;
            wr_data = rd_data;
            ptr_in = ptr_ff - 1'b1;
            state_in = psrl_pkg::S_SHIFT_RD;
         end
         psrl_pkg::S_DONE: begin
            full_in = (count_ff >= DepthC);
            valid_in = 1'b1;
            state_in = psrl_pkg::S_IDLE;
         end
         default: state_in = psrl_pkg::S_IDLE;
      endcase
   end

   assert property (@(posedge clock) disable iff (reset) count_ff <= DepthC)
      else $error("entry count above depth");
   assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> state_ff == psrl_pkg::S_IDLE)
      else $error("result shown while busy");
   assert property (@(posedge clock) disable iff (reset)
      valid_ff && stat_ff == psrl_pkg::ST_CLEARED |-> count_ff == '0 && !full_ff)
      else $error("clear left entries");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == psrl_pkg::S_SEARCH || state_ff == psrl_pkg::S_PROBE) |-> lo_ff <= hi_ff)
      else $error("search bounds crossed");
endmodule
`default_nettype wire
